[design/sle_pkg.sv]
package sle_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int REQ_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEL_MISS  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SRCH_MISS = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic capture;
    logic apply;
  } cmd_t;

endpackage

[design/sorted_list_engine_top.sv]
// Sorted list engine: holds up to CAPACITY signed 32-bit values in ascending
// order in a row of cells and serves one insert, delete or search request per
// transfer, returning a status and the entry count after the request. The
// accepting edge registers a compare of the value against every cell; then,
// in the apply state, the cells shift and the result is loaded. A new request
// is taken once the previous result has been transferred or is being
// transferred in the same cycle. Request type 3 acts as a search.
module sorted_list_engine_top #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sle_pkg::IN_TDATA_W-1:0]    in_tdata,   // req_type[1:0], value[33:2]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sle_pkg::OUT_TDATA_W-1:0]   out_tdata   // status[2:0], entry_count[7:3]
);
  import sle_pkg::*;

  cmd_t                 cmd;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   entry_count;

  sle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_type    (in_tdata[REQ_W-1:0]),
    .value       (in_tdata[REQ_W+VALUE_W-1:REQ_W]),
    .status      (status),
    .entry_count (entry_count)
  );

  assign out_tdata = {entry_count, status};

endmodule

[design/sle_ctrl.sv]
module sle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output sle_pkg::cmd_t cmd
);
  import sle_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_tready   = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.apply   = (state_r == S_APPLY);
  assign out_tvalid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd.capture) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_apply_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> !out_valid_r)
    else $error("apply while result slot occupied");

  a_apply_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |=> (out_valid_r && state_r == S_IDLE))
    else $error("apply did not present a result");

endmodule

[design/sle_datapath.sv]
module sle_datapath #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sle_pkg::cmd_t                  cmd,
  input  logic [sle_pkg::REQ_W-1:0]      req_type,
  input  logic signed [sle_pkg::VALUE_W-1:0] value,
  output logic [sle_pkg::STATUS_W-1:0]   status,
  output logic [sle_pkg::COUNT_W-1:0]    entry_count
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] cell_r  [CAPACITY];
  logic signed [VALUE_W-1:0] ins_val [CAPACITY];
  logic signed [VALUE_W-1:0] del_val [CAPACITY];
  logic [CAPACITY-1:0]       lt_r, lt_nxt, eq_r, eq_nxt;
  logic [REQ_W-1:0]          req_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic                      found, full, empty, do_ins, do_del;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic held;
    assign held      = CW'(k) < count_r;
    assign lt_nxt[k] = held && (cell_r[k] < value);
    assign eq_nxt[k] = held && (cell_r[k] == value);

    if (k == 0) begin : g_first
      assign ins_val[k] = value_r;
    end else begin : g_rest
      assign ins_val[k] = lt_r[k-1] ? value_r : cell_r[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign del_val[k] = cell_r[k];
    end else begin : g_inner
      assign del_val[k] = cell_r[k+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CAPACITY; k++) begin
      if (do_ins && !lt_r[k]) begin
        cell_r[k] <= ins_val[k];
      end else if (do_del && !lt_r[k]) begin
        cell_r[k] <= del_val[k];
      end
    end
  end

  assign found = |eq_r;
  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (cmd.apply) begin
      unique case (req_r)
        REQ_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            do_ins     = 1'b1;
            count_nxt  = count_r + 1'b1;
            status_nxt = ST_INSERTED;
          end
        end
        REQ_DELETE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else if (!found) begin
            status_nxt = ST_DEL_MISS;
          end else begin
            do_del     = 1'b1;
            count_nxt  = count_r - 1'b1;
            status_nxt = ST_DELETED;
          end
        end
        default: status_nxt = found ? ST_FOUND : ST_SRCH_MISS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= req_type;
      value_r <= value;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign status      = status_r;
  assign entry_count = COUNT_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.apply)) |-> $stable(count_r))
    else $error("entry count moved without an apply");

endmodule
